// ===== hdl/sac_pkg.sv =====
`default_nettype none

package sac_pkg;

    // Fixed field widths.
    localparam int ADDR_W    = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int WAY_OUT_W = 2;

    // Default geometry.
    localparam int SETS_DEF = 16;
    localparam int WAYS_DEF = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE    = 1'b1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_BLOCK_OFFSET_BITS = 5'd4;
    localparam logic             RST_WRITE_ALLOCATE    = 1'b1;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Control of the lookup stage.
    typedef struct packed {
        logic valid;
        logic opcode;
    } t_stage_ctl;

    // One result beat.
    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 evicted;
        logic                 evicted_dirty;
        logic [ADDR_W-1:0]    evicted_line;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/sac_index.sv =====
`default_nettype none

// Address front end: block number, then set index, over three stages.
module sac_index
    import sac_pkg::*;
#(
    parameter  int SETS = SETS_DEF,
    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_accept,
    input  wire logic              i_opcode,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [CFG_W-1:0]  i_offset,
    output logic [SW-1:0]          o_rd_set,
    output t_stage_ctl             o_s2_ctl,
    output logic [ADDR_W-1:0]      o_s2_block,
    output logic [SW-1:0]          o_s2_set
);

    logic              r0_v, r1_v, r2_v;
    logic              r0_op, r1_op, r2_op;
    logic [ADDR_W-1:0] r0_block, r1_block, r2_block;
    logic [SW-1:0]     r2_set;
    logic [SW-1:0]     n_set;

    // Stage valid bits advance together with the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_accept;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    // Stage payload; the offset shift happens on the way in.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_op    <= i_opcode;
            r0_block <= i_address >> i_offset;
            r1_op    <= r0_op;
            r1_block <= r0_block;
            r2_op    <= r1_op;
            r2_block <= r1_block;
            r2_set   <= n_set;
        end
    end

    // Set index: block modulo SETS.
    generate
        if (SETS == 1) begin : g_one_set
            assign n_set = '0;
        end else if ((SETS & (SETS - 1)) == 0) begin : g_pow2
            assign n_set = r1_block[SW-1:0];
        end else begin : g_recip
            localparam logic [63:0] RECIP64 = (64'd1 << 32) / SETS;
            localparam logic [31:0] RECIP   = RECIP64[31:0];
            localparam int          RBW     = $clog2(SETS) + 1;
            localparam logic [RBW-1:0] SETS_LO = RBW'(SETS);

            logic [63:0]       n_prod;
            logic [ADDR_W-1:0] r1_qest;
            logic [RBW-1:0]    qd_lo;
            logic [RBW-1:0]    rem_raw;
            logic [RBW-1:0]    rem;

            // Quotient estimate by reciprocal; it is exact or one low.
            assign n_prod = 64'(r0_block) * 64'(RECIP);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r1_qest <= n_prod[63:32];
                end
            end

            // The remainder is below twice SETS, so only its low bits matter.
            assign qd_lo   = r1_qest[RBW-1:0] * SETS_LO;
            assign rem_raw = r1_block[RBW-1:0] - qd_lo;
            assign rem     = (rem_raw >= SETS_LO) ? rem_raw - SETS_LO : rem_raw;
            assign n_set   = rem[SW-1:0];
        end
    endgenerate

    assign o_rd_set        = n_set;
    assign o_s2_ctl.valid  = r2_v;
    assign o_s2_ctl.opcode = r2_op;
    assign o_s2_block      = r2_block;
    assign o_s2_set        = r2_set;

endmodule

`default_nettype wire

// ===== hdl/sac_tmem.sv =====
`default_nettype none

// Set-indexed row memory with write forwarding and a clearing pass after reset.
module sac_tmem
    import sac_pkg::*;
#(
    parameter  int SETS = SETS_DEF,
    parameter  int WAYS = WAYS_DEF,
    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_rd_en,
    input  wire logic [SW-1:0]                    i_rd_set,
    input  wire logic                             i_wr_en,
    input  wire logic [SW-1:0]                    i_wr_set,
    input  wire logic [WAYS-1:0]                  i_wr_valid,
    input  wire logic [WAYS-1:0]                  i_wr_dirty,
    input  wire logic [WAYS-1:0][WW-1:0]          i_wr_rank,
    input  wire logic [WAYS-1:0][ADDR_W-1:0]      i_wr_blk,
    output logic [WAYS-1:0]                       o_rd_valid,
    output logic [WAYS-1:0]                       o_rd_dirty,
    output logic [WAYS-1:0][WW-1:0]               o_rd_rank,
    output logic [WAYS-1:0][ADDR_W-1:0]           o_rd_blk,
    output logic                                  o_clr_busy
);

    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0]             dirty;
        logic [WAYS-1:0][WW-1:0]     rank;
        logic [WAYS-1:0][ADDR_W-1:0] blk;
    } t_row;

    t_row          r_mem [SETS];
    t_row          wr_row;
    t_row          r_mem_q;
    t_row          r_fwd_row;
    t_row          rd_row;
    logic          r_fwd;
    logic          r_clr_busy;
    logic [SW-1:0] r_clr_idx;

    assign wr_row.valid = i_wr_valid;
    assign wr_row.dirty = i_wr_dirty;
    assign wr_row.rank  = i_wr_rank;
    assign wr_row.blk   = i_wr_blk;

    // Clearing pass: one set per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_idx == SW'(SETS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // Write port.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_set] <= wr_row;
        end
    end

    // Read port; a same-cycle write to the same set is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q   <= r_mem[i_rd_set];
            r_fwd     <= i_wr_en && (i_wr_set == i_rd_set);
            r_fwd_row <= wr_row;
        end
    end

    assign rd_row     = r_fwd ? r_fwd_row : r_mem_q;
    assign o_rd_valid = rd_row.valid;
    assign o_rd_dirty = rd_row.dirty;
    assign o_rd_rank  = rd_row.rank;
    assign o_rd_blk   = rd_row.blk;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

// ===== hdl/sac_lookup.sv =====
`default_nettype none

// Tag compare, victim choice, LRU refresh and the updated set row.
module sac_lookup
    import sac_pkg::*;
#(
    parameter  int WAYS = WAYS_DEF,
    localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  wire logic                        i_opcode,
    input  wire logic [ADDR_W-1:0]           i_block,
    input  wire logic                        i_write_allocate,
    input  wire logic [WAYS-1:0]             i_valid,
    input  wire logic [WAYS-1:0]             i_dirty,
    input  wire logic [WAYS-1:0][WW-1:0]     i_rank,
    input  wire logic [WAYS-1:0][ADDR_W-1:0] i_blk,
    output t_result                          o_res,
    output logic [WAYS-1:0]                  o_valid,
    output logic [WAYS-1:0]                  o_dirty,
    output logic [WAYS-1:0][WW-1:0]          o_rank,
    output logic [WAYS-1:0][ADDR_W-1:0]      o_blk
);

    localparam logic [WW-1:0] TOP_RANK = WW'(WAYS - 1);

    logic            hit;
    logic [WW-1:0]   hit_way;
    logic            inv_any;
    logic [WW-1:0]   inv_way;
    logic [WW-1:0]   lru_way;
    logic [WW-1:0]   way;
    logic [WW+1:0]   way_ext;
    logic            fill;
    logic            touch;
    logic            evict;
    logic [WW-1:0]   old_rank;

    // Priority encoders: lowest matching way wins in each search.
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        lru_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_blk[i] == i_block)) begin
                hit     = 1'b1;
                hit_way = WW'(i);
            end
            if (!i_valid[i]) begin
                inv_any = 1'b1;
                inv_way = WW'(i);
            end
            // With every way valid the ranks are distinct, so rank zero is the minimum.
            if (i_rank[i] == '0) begin
                lru_way = WW'(i);
            end
        end
    end

    // Way selection and what happens to it.
    assign fill     = !hit && ((i_opcode == OP_READ) || i_write_allocate);
    assign touch    = hit || fill;
    assign way      = hit ? hit_way : (inv_any ? inv_way : lru_way);
    assign old_rank = i_rank[way];
    assign evict    = fill && i_valid[way];
    assign way_ext  = (WW + 2)'(way);

    // Updated row.
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            o_valid[i] = i_valid[i];
            o_dirty[i] = i_dirty[i];
            o_rank[i]  = i_rank[i];
            o_blk[i]   = i_blk[i];
            if (touch) begin
                if (way == WW'(i)) begin
                    o_rank[i] = TOP_RANK;
                end else if (i_rank[i] > old_rank) begin
                    o_rank[i] = i_rank[i] - 1'b1;
                end
            end
            if (way == WW'(i)) begin
                if (fill) begin
                    o_valid[i] = 1'b1;
                    o_dirty[i] = (i_opcode == OP_WRITE);
                    o_blk[i]   = i_block;
                end else if (hit && (i_opcode == OP_WRITE)) begin
                    o_dirty[i] = 1'b1;
                end
            end
        end
    end

    // Result beat.
    assign o_res.hit           = hit;
    assign o_res.way_used      = touch ? way_ext[WAY_OUT_W-1:0] : '0;
    assign o_res.evicted       = evict;
    assign o_res.evicted_dirty = evict && i_dirty[way];
    assign o_res.evicted_line  = evict ? i_blk[way] : '0;

endmodule

`default_nettype wire

// ===== hdl/set_assoc_lru_cache_tags.sv =====
// An access passes the index stages and the output register. Throughput: one
// access per cycle while the output is not held; the tag row memory is read once
// and written once per cycle, with same-set writes forwarded to the next read.
// Reset (synchronous, active low) clears the pipeline and resets the registers,
// then a clearing pass zeroes one set per cycle with input ready low.
`default_nettype none

module set_assoc_lru_cache_tags
    import sac_pkg::*;
#(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_opcode,
    input  wire logic [ADDR_W-1:0]    i_address,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_hit,
    output logic [WAY_OUT_W-1:0]      o_way_used,
    output logic                      o_evicted,
    output logic                      o_evicted_dirty,
    output logic [ADDR_W-1:0]         o_evicted_line
);

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [CFG_W-1:0]            r_block_offset_bits;
    logic                        r_write_allocate;
    logic                        r_out_valid;
    t_result                     r_res;
    t_result                     res;

    logic                        en;
    logic                        accept;
    logic                        clr_busy;
    logic [SW-1:0]               rd_set;
    t_stage_ctl                  s2_ctl;
    logic [ADDR_W-1:0]           s2_block;
    logic [SW-1:0]               s2_set;

    logic [WAYS-1:0]             rd_valid, wr_valid;
    logic [WAYS-1:0]             rd_dirty, wr_dirty;
    logic [WAYS-1:0][WW-1:0]     rd_rank, wr_rank;
    logic [WAYS-1:0][ADDR_W-1:0] rd_blk, wr_blk;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_offset_bits <= RST_BLOCK_OFFSET_BITS;
            r_write_allocate    <= RST_WRITE_ALLOCATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLOCK_OFFSET_BITS: r_block_offset_bits <= i_cfg_data;
                CFG_WRITE_ALLOCATE:    r_write_allocate    <= i_cfg_data[0];
            endcase
        end
    end

    // The whole pipeline moves whenever the output register can take a beat.
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en && !clr_busy;
    assign accept     = i_in_valid && o_in_ready;

    sac_index #(
        .SETS (SETS)
    ) u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_accept   (accept),
        .i_opcode   (i_opcode),
        .i_address  (i_address),
        .i_offset   (r_block_offset_bits),
        .o_rd_set   (rd_set),
        .o_s2_ctl   (s2_ctl),
        .o_s2_block (s2_block),
        .o_s2_set   (s2_set)
    );

    sac_tmem #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_tmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (en),
        .i_rd_set   (rd_set),
        .i_wr_en    (en && s2_ctl.valid),
        .i_wr_set   (s2_set),
        .i_wr_valid (wr_valid),
        .i_wr_dirty (wr_dirty),
        .i_wr_rank  (wr_rank),
        .i_wr_blk   (wr_blk),
        .o_rd_valid (rd_valid),
        .o_rd_dirty (rd_dirty),
        .o_rd_rank  (rd_rank),
        .o_rd_blk   (rd_blk),
        .o_clr_busy (clr_busy)
    );

    sac_lookup #(
        .WAYS (WAYS)
    ) u_lookup (
        .i_opcode         (s2_ctl.opcode),
        .i_block          (s2_block),
        .i_write_allocate (r_write_allocate),
        .i_valid          (rd_valid),
        .i_dirty          (rd_dirty),
        .i_rank           (rd_rank),
        .i_blk            (rd_blk),
        .o_res            (res),
        .o_valid          (wr_valid),
        .o_dirty          (wr_dirty),
        .o_rank           (wr_rank),
        .o_blk            (wr_blk)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s2_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_res.hit;
    assign o_way_used      = r_res.way_used;
    assign o_evicted       = r_res.evicted;
    assign o_evicted_dirty = r_res.evicted_dirty;
    assign o_evicted_line  = r_res.evicted_line;

`ifndef ASSERT_OFF
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.hit) |-> !r_res.evicted)
        else $error("hit beat reports an eviction");

    a_dirty_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.evicted_dirty) |-> r_res.evicted)
        else $error("dirty eviction flagged without an eviction");

    a_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.evicted) |-> (r_res.evicted_line == '0))
        else $error("evicted line nonzero without an eviction");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> (!s2_ctl.valid && !r_out_valid))
        else $error("access in flight during the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== dv/cache_tag_checker.sv =====
`timescale 1ns / 100ps

// Watches the access and result channels of the cache tag store, predicts
// every result beat from its own copy of the tags, valid, dirty and LRU
// state, and compares each result beat field by field in order.
module cache_tag_checker
    import sac_pkg::*;
#(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire logic                 i_opcode,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire logic                 i_hit,
    input  wire logic [WAY_OUT_W-1:0] i_way_used,
    input  wire logic                 i_evicted,
    input  wire logic                 i_evicted_dirty,
    input  wire logic [ADDR_W-1:0]    i_evicted_line,
    output int                        o_error_count,
    output int                        o_outstanding
);

    localparam int ENTRIES = SETS * WAYS;
    localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Shadow copy of the tag store and its configuration.
    logic [ADDR_W-1:0] tag_mem    [ENTRIES];
    logic              line_valid [ENTRIES];
    logic              line_dirty [ENTRIES];
    logic [RANK_W-1:0] lru_rank   [ENTRIES];
    logic [CFG_W-1:0]  offset_bits;
    logic              fill_on_write;

    // Predicted result beats, oldest first.
    t_result predicted_lookups[$];

    int error_total = 0;
    int pending     = 0;

    assign o_error_count = error_total;
    assign o_outstanding = pending;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_total++;
    endtask

    // Make a way the most recently used one; ranks above its old rank move down.
    function automatic void promote_way(input int base, input int way);
        logic [RANK_W-1:0] old_rank;
        old_rank = lru_rank[base + way];
        for (int w = 0; w < WAYS; w++) begin
            if (lru_rank[base + w] > old_rank) begin
                lru_rank[base + w] = lru_rank[base + w] - 1'b1;
            end
        end
        lru_rank[base + way] = RANK_W'(WAYS - 1);
    endfunction

    // Lowest invalid way first, otherwise the lowest rank with ties to the lower index.
    function automatic int pick_victim(input int base);
        int best;
        best = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (best < 0 && !line_valid[base + w]) begin
                best = w;
            end
        end
        if (best >= 0) begin
            return best;
        end
        best = 0;
        for (int w = 1; w < WAYS; w++) begin
            if (lru_rank[base + w] < lru_rank[base + best]) begin
                best = w;
            end
        end
        return best;
    endfunction

    // One access against the shadow state: returns its result and updates the state.
    function automatic t_result cache_lookup(input logic op, input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] set_idx;
        logic [ADDR_W-1:0] tag;
        int                base;
        int                way;
        t_result           res;
        blk     = addr >> offset_bits;
        set_idx = blk % SETS;
        tag     = blk / SETS;
        base    = int'(set_idx) * WAYS;
        way     = -1;
        res     = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (way < 0 && line_valid[base + w] && tag_mem[base + w] == tag) begin
                way = w;
            end
        end
        if (way >= 0) begin
            res.hit      = 1'b1;
            res.way_used = WAY_OUT_W'(way);
            if (op == OP_WRITE) begin
                line_dirty[base + way] = 1'b1;
            end
            promote_way(base, way);
        end else if (op == OP_READ || fill_on_write) begin
            way = pick_victim(base);
            if (line_valid[base + way]) begin
                res.evicted       = 1'b1;
                res.evicted_dirty = line_dirty[base + way];
                res.evicted_line  = tag_mem[base + way] * SETS + set_idx;
            end
            promote_way(base, way);
            tag_mem[base + way]    = tag;
            line_valid[base + way] = 1'b1;
            line_dirty[base + way] = (op == OP_WRITE);
            res.way_used           = WAY_OUT_W'(way);
        end
        return res;
    endfunction

    // Track register writes, predict on each access beat, compare on each result beat.
    always @(posedge i_clk) begin : monitor
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                tag_mem[e]    = '0;
                line_valid[e] = 1'b0;
                line_dirty[e] = 1'b0;
                lru_rank[e]   = '0;
            end
            offset_bits   = RST_BLOCK_OFFSET_BITS;
            fill_on_write = RST_WRITE_ALLOCATE;
            predicted_lookups.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLOCK_OFFSET_BITS: offset_bits   = i_cfg_data;
                    CFG_WRITE_ALLOCATE:    fill_on_write = i_cfg_data[0];
                    default: ;
                endcase
            end
            // The result side is checked first so that a beat can never match
            // an access accepted at the same edge.
            if (i_out_valid && i_out_ready) begin
                seen = '{i_hit, i_way_used, i_evicted, i_evicted_dirty, i_evicted_line};
                if (predicted_lookups.size() == 0) begin
                    flag_error("result beat with no access outstanding");
                end else begin
                    want = predicted_lookups.pop_front();
                    if (seen.hit !== want.hit) begin
                        flag_error($sformatf("hit %b, expected %b", seen.hit, want.hit));
                    end
                    if (seen.way_used !== want.way_used) begin
                        flag_error($sformatf("way_used %0d, expected %0d",
                                             seen.way_used, want.way_used));
                    end
                    if (seen.evicted !== want.evicted) begin
                        flag_error($sformatf("evicted %b, expected %b",
                                             seen.evicted, want.evicted));
                    end
                    if (seen.evicted_dirty !== want.evicted_dirty) begin
                        flag_error($sformatf("evicted_dirty %b, expected %b",
                                             seen.evicted_dirty, want.evicted_dirty));
                    end
                    if (seen.evicted_line !== want.evicted_line) begin
                        flag_error($sformatf("evicted_line %h, expected %h",
                                             seen.evicted_line, want.evicted_line));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_lookups.push_back(cache_lookup(i_opcode, i_address));
            end
        end
        pending = predicted_lookups.size();
    end

endmodule

// ===== dv/set_assoc_lru_cache_tags_test.sv =====
`timescale 1ns / 100ps

module set_assoc_lru_cache_tags_test;
    import sac_pkg::*;

    localparam int SETS          = SETS_DEF;
    localparam int WAYS          = WAYS_DEF;
    localparam int PHASES        = 8;
    localparam int ITEMS_PER_SET = 94;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_opcode;
    logic [ADDR_W-1:0]    i_address;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_hit;
    logic [WAY_OUT_W-1:0] o_way_used;
    logic                 o_evicted;
    logic                 o_evicted_dirty;
    logic [ADDR_W-1:0]    o_evicted_line;

    int mismatch_count;
    int pending_lookups;

    // Offset width and write-allocate of each phase, extremes included.
    int phase_offset [PHASES] = '{4, 0, 16, 31, 17, 2, 9, 6};
    bit phase_alloc  [PHASES] = '{1, 0, 1, 0, 1, 1, 0, 1};

    set_assoc_lru_cache_tags #(
        .SETS(SETS),
        .WAYS(WAYS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_way_used     (o_way_used),
        .o_evicted      (o_evicted),
        .o_evicted_dirty(o_evicted_dirty),
        .o_evicted_line (o_evicted_line)
    );

    cache_tag_checker #(
        .SETS(SETS),
        .WAYS(WAYS)
    ) lookup_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_hit          (o_hit),
        .i_way_used     (o_way_used),
        .i_evicted      (o_evicted),
        .i_evicted_dirty(o_evicted_dirty),
        .i_evicted_line (o_evicted_line),
        .o_error_count  (mismatch_count),
        .o_outstanding  (pending_lookups)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side stalls on a pattern whose mode is redrawn at random each time its countdown runs out.
    t_rx_mode rx_mode   = RX_ALWAYS;
    int       rx_left   = 40;
    int       rx_cycles = 0;

    always @(posedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:   i_out_ready <= rx_cycles[2];
        endcase
    end

    // Watchdog: ends the run when work is waiting but no beat moves for too long.
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (i_in_valid || pending_lookups != 0) begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("set_assoc_lru_cache_tags verification failed");
            $finish;
        end
    end

    // Present one access and hold it until the block takes it.
    task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr);
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_address  <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending and wait for every predicted result to come back.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges.
    task automatic load_settings(input int off, input bit alloc);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BLOCK_OFFSET_BITS;
        i_cfg_data  <= CFG_W'(off);
        @(posedge i_clk);
        i_cfg_index <= CFG_WRITE_ALLOCATE;
        i_cfg_data  <= CFG_W'(alloc);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] line_address(input logic [ADDR_W-1:0] tag,
                                                        input int set_idx, input int off);
        logic [ADDR_W-1:0] blk;
        blk = tag * SETS + set_idx;
        return blk << off;
    endfunction

    // Stimulus: directed corner cases, then random phases under several settings.
    initial begin : stimulus
        logic [ADDR_W-1:0] tag_pool [6];
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] addr;
        logic              op;
        int                off;
        int                set_base;
        int                sent;
        int                burst;
        int                gap;
        int                roll;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_BLOCK_OFFSET_BITS;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_READ;
        i_address   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            drain_pipeline();
            off = phase_offset[p];
            load_settings(off, phase_alloc[p]);

            if (p == 0) begin
                // Hit after fill, offset bits ignored, write hit marks dirty.
                send_access(OP_READ,  32'h0000_0000);
                send_access(OP_READ,  32'h0000_000F);
                send_access(OP_WRITE, 32'h0000_0000);
                send_access(OP_READ,  32'hFFFF_FFFF);
                send_access(OP_WRITE, 32'hFFFF_FFFF);
                // Fill a set, then evict a dirty line and later a clean one.
                send_access(OP_WRITE, line_address(5, 3, off));
                send_access(OP_READ,  line_address(1, 3, off));
                send_access(OP_READ,  line_address(2, 3, off));
                send_access(OP_READ,  line_address(3, 3, off));
                send_access(OP_READ,  line_address(4, 3, off));
                send_access(OP_READ,  line_address(1, 3, off));
                send_access(OP_WRITE, line_address(6, 3, off));
                send_access(OP_WRITE, 32'h8000_0000);
            end else if (p == 1) begin
                // Write misses bypass with allocation off; reads still fill.
                send_access(OP_WRITE, 32'h1234_5678);
                send_access(OP_READ,  32'h1234_5678);
                send_access(OP_WRITE, 32'h1234_5678);
                send_access(OP_WRITE, 32'hFFFF_FFFF);
                send_access(OP_READ,  32'h0000_0000);
            end

            // A few small tags and a few wide ones, aimed at four neighboring sets.
            for (int k = 0; k < 6; k++) begin
                tag_pool[k] = (k < 4) ? ADDR_W'($urandom_range(0, 7)) : ADDR_W'($urandom);
            end
            set_base = $urandom_range(0, SETS - 4);
            low_mask = (off == 0) ? '0 : ((ADDR_W'(1) << off) - 1'b1);

            sent = 0;
            while (sent < ITEMS_PER_SET) begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst && sent < ITEMS_PER_SET; b++) begin
                    roll = $urandom_range(0, 99);
                    op   = 1'($urandom_range(0, 1));
                    if (roll < 85) begin
                        addr = line_address(tag_pool[$urandom_range(0, 5)],
                                            set_base + $urandom_range(0, 3), off)
                               | (ADDR_W'($urandom) & low_mask);
                    end else if (roll < 96) begin
                        addr = $urandom;
                    end else begin
                        addr = ($urandom_range(0, 1) == 1) ? '1 : '0;
                    end
                    send_access(op, addr);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("set_assoc_lru_cache_tags verification clean");
        end else begin
            $display("set_assoc_lru_cache_tags verification failed");
        end
        $finish;
    end

endmodule
